>>> src/sha1h_pkg.sv
package sha1h_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] words5_t;

    // Round constants, one per group of twenty rounds.
    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    // Initial chaining value, element 0 is H0.
    localparam words5_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] SCHED_LOAD_ROUNDS = 7'd16;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    // Request from the controller to the schedule store.
    typedef struct packed {
        logic       pack_we;
        logic [3:0] pack_addr;
        word_t      pack_data;
        logic       round_we;
        logic [6:0] round;
        logic [6:0] fetch;
    } sched_req_t;

endpackage

>>> src/sha1_message_hasher_top.sv
// A request that does not complete a block is taken while idle; a request that completes
// a block is followed by a compression (load, 80 rounds, fold-in), during which no request
// is taken. Throughput is set by the one SHA-1 round per cycle that the schedule RAM read
// and the round adder allow.
// The final request adds one padding byte per cycle plus one or two compressions, then
// five digest words. Reset is synchronous, active low; the schedule RAM is not cleared.
module sha1_message_hasher_top import sha1h_pkg::*; #(
    parameter int LENGTH_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    // Controller states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [5:0]             pos_reg, pos_next;
    word_t                  word_reg, word_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    words5_t                chain_reg, chain_next;
    words5_t                vars_reg, vars_next;
    logic [6:0]             round_reg, round_next;
    logic                   final_reg, final_next;
    logic                   pad80_reg, pad80_next;
    logic                   len_ok_reg, len_ok_next;
    logic [2:0]             idx_reg, idx_next;

    logic       s_take;
    logic       put_en;
    logic [7:0] put_byte;
    logic [63:0] len64;
    logic [7:0] len_byte;
    sched_req_t sreq;
    word_t      w;
    words5_t    round_vars;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;

    // The message length is shown in the length field as 64 bits, upper bits zero
    // when the counter is narrower.
    assign len64    = 64'(count_reg);
    assign len_byte = 8'(len64 >> {~pos_reg[2:0], 3'b000});

    // Byte source: message bytes while idle, the 0x80 marker, zero fill, or length bytes.
    always_comb begin
        put_en   = 1'b0;
        put_byte = 8'h00;
        if (state_reg == ST_IDLE) begin
            put_en   = s_take && s_has_byte;
            put_byte = s_data_byte;
        end else if (state_reg == ST_PAD) begin
            put_en = 1'b1;
            if (pad80_reg) begin
                put_byte = PAD_BYTE;
            end else if (len_ok_reg && pos_reg >= LEN_FIELD_POS) begin
                put_byte = len_byte;
            end
        end
    end

    // Big-endian packing of bytes into the current schedule word.
    always_comb begin
        case (pos_reg[1:0])
            2'd0:    word_next = {put_byte, 24'h000000};
            2'd1:    word_next = {word_reg[31:24], put_byte, 16'h0000};
            2'd2:    word_next = {word_reg[31:16], put_byte, 8'h00};
            default: word_next = {word_reg[31:8], put_byte};
        endcase
    end

    always_comb begin
        sreq.pack_we   = put_en && (pos_reg[1:0] == 2'd3);
        sreq.pack_addr = pos_reg[5:2];
        sreq.pack_data = word_next;
        sreq.round_we  = (state_reg == ST_ROUND);
        sreq.round     = round_reg;
        sreq.fetch     = (state_reg == ST_ROUND) ? round_reg + 7'd1 : 7'd0;
    end

    sha1h_sched u_sched (
        .aclk(aclk),
        .req (sreq),
        .w   (w)
    );

    sha1h_round u_round (
        .vars_i(vars_reg),
        .w     (w),
        .t     (round_reg),
        .vars_o(round_vars)
    );

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        chain_next  = chain_reg;
        vars_next   = vars_reg;
        round_next  = round_reg;
        final_next  = final_reg;
        pad80_next  = pad80_reg;
        len_ok_next = len_ok_reg;
        idx_next    = idx_reg;

        if (put_en) begin
            pos_next = pos_reg + 6'd1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    if (s_has_byte) begin
                        count_next = count_reg + LENGTH_BITS'(8);
                    end
                    if (s_is_last) begin
                        final_next = 1'b1;
                        pad80_next = 1'b1;
                    end
                    if (put_en && pos_reg == BLOCK_LAST_POS) begin
                        state_next = ST_LOAD;
                    end else if (s_is_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pad80_reg) begin
                    pad80_next  = 1'b0;
                    // The length fits behind the marker only when it lands before byte 56.
                    len_ok_next = pos_reg < LEN_FIELD_POS;
                end
                if (pos_reg == BLOCK_LAST_POS) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                vars_next  = chain_reg;
                round_next = 7'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                vars_next = round_vars;
                if (round_reg == LAST_ROUND) begin
                    round_next = 7'd0;
                    state_next = ST_FIN;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_FIN: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                if (!final_reg) begin
                    state_next = ST_IDLE;
                end else if (pad80_reg) begin
                    state_next = ST_PAD;
                end else if (len_ok_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else begin
                    // The marker block overflowed; the next block carries the length.
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == LAST_WORD_IDX) begin
                        chain_next = H_INIT;
                        count_next = '0;
                        final_next = 1'b0;
                        idx_next   = 3'd0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            count_reg  <= '0;
            chain_reg  <= H_INIT;
            round_reg  <= '0;
            final_reg  <= 1'b0;
            pad80_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            chain_reg  <= chain_next;
            round_reg  <= round_next;
            final_reg  <= final_next;
            pad80_reg  <= pad80_next;
            len_ok_reg <= len_ok_next;
            idx_reg    <= idx_next;
        end
    end

    // Working variables and the partial word are payload and need no reset.
    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
        if (put_en) begin
            word_reg <= word_next;
        end
    end

    // The digest words are presented straight from the chaining registers.
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == LAST_WORD_IDX);

endmodule

>>> src/sha1h_ram.sv
module sha1h_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sha1h_sched.sv
module sha1h_sched import sha1h_pkg::*; (
    input  logic       aclk,
    input  sched_req_t req,
    output word_t      w
);

    // Four identical copies of the window read the four taps of the schedule recurrence
    // together: t-16 (held in the slot of t), t-3, t-8 and t-14.
    localparam int NUM_TAPS = 4;
    localparam logic [6:0] TAP_OFS [NUM_TAPS] = '{7'd0, 7'd3, 7'd8, 7'd14};

    word_t      q [NUM_TAPS];
    logic [3:0] ra [NUM_TAPS];
    logic       we;
    logic [3:0] waddr;
    word_t      wdata;
    word_t      mix;

    always_comb begin
        mix = q[0] ^ q[1] ^ q[2] ^ q[3];
        if (req.round < SCHED_LOAD_ROUNDS) begin
            w = q[0];
        end else begin
            w = {mix[30:0], mix[31]};
        end
        if (req.round_we) begin
            we    = req.round >= SCHED_LOAD_ROUNDS;
            waddr = req.round[3:0];
            wdata = w;
        end else begin
            we    = req.pack_we;
            waddr = req.pack_addr;
            wdata = req.pack_data;
        end
    end

    for (genvar i = 0; i < NUM_TAPS; i++) begin : g_tap
        logic [6:0] tap_round;
        assign tap_round = req.fetch - TAP_OFS[i];
        assign ra[i] = tap_round[3:0];
        sha1h_ram #(
            .WIDTH(32),
            .DEPTH(16)
        ) u_ram (
            .aclk (aclk),
            .we   (we),
            .waddr(waddr),
            .wdata(wdata),
            .raddr(ra[i]),
            .rdata(q[i])
        );
    end

endmodule

>>> src/sha1h_round.sv
module sha1h_round import sha1h_pkg::*; (
    input  words5_t    vars_i,
    input  word_t      w,
    input  logic [6:0] t,
    output words5_t    vars_o
);

    word_t a, b, c, d, e, f, k;

    always_comb begin
        a = vars_i[0];
        b = vars_i[1];
        c = vars_i[2];
        d = vars_i[3];
        e = vars_i[4];
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
            k = K_0;
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
            k = K_1;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
        end else begin
            f = b ^ c ^ d;
            k = K_3;
        end
        vars_o[0] = {a[26:0], a[31:27]} + f + e + w + k;
        vars_o[1] = a;
        vars_o[2] = {b[1:0], b[31:2]};
        vars_o[3] = c;
        vars_o[4] = d;
    end

endmodule
